>>> sv/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants of the program-stream PES deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

  localparam logic [31:0] CODE_VIDEO = 32'h0000_01E0;
  localparam logic [31:0] CODE_AUDIO = 32'h0000_01C0;

  // number of length bytes that complete the packet header
  localparam logic [1:0] PHASE_LEN_DONE = 2'd2;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       stream_is_audio;
    logic       last_byte;
    logic       empty_packet;
  } result_t;

  function automatic logic is_start_code(input logic [31:0] w);
    return (w == CODE_VIDEO) || (w == CODE_AUDIO);
  endfunction

endpackage

`default_nettype wire

>>> sv/mpd_if.sv
// ----------------------------------------------------------------------------
// mpd_if
// Valid/ready channels: raw stream bytes in, deframed results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface mpd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       stream_is_audio;
  logic       last_byte;
  logic       empty_packet;

  modport source (
    output valid, output payload_byte, output stream_is_audio,
    output last_byte, output empty_packet, input ready
  );
  modport sink (
    input valid, input payload_byte, input stream_is_audio,
    input last_byte, input empty_packet, output ready
  );
endinterface

`default_nettype wire

>>> sv/mpd_in_stage.sv
// ----------------------------------------------------------------------------
// mpd_in_stage
// Input register: captures one stream byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_in_stage (
  input  wire logic  clk,
  input  wire logic  rst,
  mpd_byte_if.sink   stream,
  input  wire logic  advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign stream.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (stream.ready) begin
      held_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      held_byte <= stream.in_byte;
    end
  end

endmodule

`default_nettype wire

>>> sv/mpd_parser.sv
// ----------------------------------------------------------------------------
// mpd_parser
// Start-code hunt, length capture and payload count for one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] in_byte,
  output logic            res_valid,
  output mpd_pkg::result_t res
);

  logic [31:0] start_window, start_window_next;
  logic [1:0]  length_phase, length_phase_next;
  logic [15:0] packet_length, packet_length_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [15:0] rem_dec;
  logic        audio;

  assign audio = (start_window == mpd_pkg::CODE_AUDIO);
  assign rem_dec = (bytes_remaining != 16'd0) ? bytes_remaining - 16'd1 : bytes_remaining;

  always_comb begin
    start_window_next    = start_window;
    length_phase_next    = length_phase;
    packet_length_next   = packet_length;
    bytes_remaining_next = bytes_remaining;
    res_valid            = 1'b0;
    res                  = '0;
    res.stream_is_audio  = audio;
    if (!mpd_pkg::is_start_code(start_window)) begin
      // hunting: shift the byte into the window
      start_window_next = {start_window[23:0], in_byte};
      length_phase_next = 2'd0;
      if (mpd_pkg::is_start_code(start_window_next)) begin
        packet_length_next = 16'd0;
      end
    end else if (length_phase < mpd_pkg::PHASE_LEN_DONE) begin
      packet_length_next = {packet_length[7:0], in_byte};
      length_phase_next  = 2'(length_phase + 2'd1);
      if (length_phase_next == mpd_pkg::PHASE_LEN_DONE) begin
        bytes_remaining_next = packet_length_next;
        if (packet_length_next == 16'd0) begin
          // empty packet: one marker result, then hunt again
          res_valid         = 1'b1;
          res.last_byte     = 1'b1;
          res.empty_packet  = 1'b1;
          start_window_next = 32'd0;
          length_phase_next = 2'd0;
        end
      end
    end else begin
      bytes_remaining_next = rem_dec;
      res_valid            = 1'b1;
      res.payload_byte     = in_byte;
      res.last_byte        = (rem_dec == 16'd0);
      if (rem_dec == 16'd0) begin
        start_window_next = 32'd0;
        length_phase_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_window    <= 32'd0;
      length_phase    <= 2'd0;
      packet_length   <= 16'd0;
      bytes_remaining <= 16'd0;
    end else if (step) begin
      start_window    <= start_window_next;
      length_phase    <= length_phase_next;
      packet_length   <= packet_length_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/mpd_out_stage.sv
// ----------------------------------------------------------------------------
// mpd_out_stage
// Result register: holds one result until the receiver takes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_out_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire logic            res_valid,
  input  mpd_pkg::result_t     res,
  output logic                 can_load,
  mpd_result_if.source         packet
);

  mpd_pkg::result_t data;

  assign can_load = !packet.valid || packet.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet.valid <= 1'b0;
    end else if (can_load) begin
      packet.valid <= load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load && res_valid) begin
      data <= res;
    end
  end

  assign packet.payload_byte    = data.payload_byte;
  assign packet.stream_is_audio = data.stream_is_audio;
  assign packet.last_byte       = data.last_byte;
  assign packet.empty_packet    = data.empty_packet;

endmodule

`default_nettype wire

>>> sv/mpeg_pes_deframer_core.sv
// ----------------------------------------------------------------------------
// mpeg_pes_deframer_core
// Program-stream PES deframer: hunts for video/audio start codes and passes
// each packet's payload bytes on, tagged and with the final byte marked.
// ----------------------------------------------------------------------------
// Usage:
//   stream carries raw program-stream bytes, one per beat. packet carries
//   results: payload bytes tagged video (E0) or audio (C0), last_byte on the
//   final byte, and a single empty_packet beat for a zero-length packet.
//   Start-code bytes and length bytes produce no result.
// Path: an accepted byte passes through the input register, then one decode
//   step into the result register on its way to packet.
// Throughput: one byte per cycle while packet.ready does not stall; the decode
//   loop runs from and back into the window, length and remaining-count registers.
// Reset (synchronous rst): window, length phase and counters clear, both
//   register stages empty; hunting starts with the next byte.
// Stall: while a result waits on packet.ready the held input byte waits too;
//   stream.ready drops only when both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg_pes_deframer_core (
  input  wire logic    clk,
  input  wire logic    rst,
  mpd_byte_if.sink     stream,
  mpd_result_if.source packet
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             can_load;
  logic             advance;
  logic             res_valid;
  mpd_pkg::result_t res;

  assign advance = held_valid && can_load;

  mpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  mpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .in_byte   (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  mpd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .packet    (packet)
  );

endmodule

`default_nettype wire

>>> sv/mpd_checker.sv
// ----------------------------------------------------------------------------
// mpd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] payload_byte,
  input wire logic       stream_is_audio,
  input wire logic       last_byte,
  input wire logic       empty_packet
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte)
      && $stable(stream_is_audio) && $stable(last_byte) && $stable(empty_packet))
    else $error("result beat changed while stalled");

  // empty packet beat ends the packet and carries no byte
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_packet |-> last_byte && (payload_byte == 8'd0))
    else $error("empty packet beat malformed");

  // a fresh result follows an input beat taken through the input register
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an input beat");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind mpeg_pes_deframer_core mpd_checker u_mpd_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (stream.valid),
  .in_ready        (stream.ready),
  .out_valid       (packet.valid),
  .out_ready       (packet.ready),
  .payload_byte    (packet.payload_byte),
  .stream_is_audio (packet.stream_is_audio),
  .last_byte       (packet.last_byte),
  .empty_packet    (packet.empty_packet)
);

`default_nettype wire

>>> verif/mpeg_pes_deframer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpeg_pes_deframer_core_tb
// Self-checking bench for the PES deframer. Feeds program-stream bytes built
// from headers, lengths, payloads and filler. A behavioral deframer predicts
// each result, and every packet beat is checked against it field by field.
// ----------------------------------------------------------------------------

module mpeg_pes_deframer_core_tb;

  localparam int PAYLOAD_TARGET = 650;
  localparam int QUIET_TAIL     = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_PAUSE      = 12;

  localparam logic [23:0] CODE_PREFIX = mpd_pkg::CODE_VIDEO[31:8];
  localparam logic [7:0]  ID_VIDEO    = mpd_pkg::CODE_VIDEO[7:0];
  localparam logic [7:0]  ID_AUDIO    = mpd_pkg::CODE_AUDIO[7:0];

  logic clk = 1'b0;
  logic rst = 1'b1;

  mpd_byte_if   stream_ch ();
  mpd_result_if packet_ch ();

  mpeg_pes_deframer_core uut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .packet (packet_ch)
  );

  always #2 clk = ~clk;

  logic [7:0]        stream_bytes[$];
  mpd_pkg::result_t  expected_results[$];

  // behavioral deframer state
  logic [31:0] scan_window;
  logic [1:0]  hdr_count;
  logic [15:0] pkt_len;
  logic [15:0] remaining;

  int  errors         = 0;
  int  idle_cycles    = 0;
  int  src_gap        = 0;
  int  sink_gap       = 0;
  bit  byte_taken     = 1'b0;

  function automatic bit code_seen(input logic [31:0] w);
    return (w == mpd_pkg::CODE_VIDEO) || (w == mpd_pkg::CODE_AUDIO);
  endfunction

  function automatic bit steady();
    return stream_bytes.size() < QUIET_TAIL;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
  endtask

  task automatic rescan();
    scan_window = '0;
    hdr_count   = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    mpd_pkg::result_t r;
    logic             audio;
    if (!code_seen(scan_window)) begin
      scan_window = {scan_window[23:0], b};
      hdr_count   = '0;
      if (code_seen(scan_window)) pkt_len = '0;
    end else begin
      audio = (scan_window == mpd_pkg::CODE_AUDIO);
      if (hdr_count < mpd_pkg::PHASE_LEN_DONE) begin
        pkt_len   = {pkt_len[7:0], b};
        hdr_count = hdr_count + 2'd1;
        if (hdr_count == mpd_pkg::PHASE_LEN_DONE) begin
          remaining = pkt_len;
          if (remaining == '0) begin
            r = '{payload_byte: 8'h00, stream_is_audio: audio, last_byte: 1'b1,
                  empty_packet: 1'b1};
            expected_results.push_back(r);
            rescan();
          end
        end
      end else begin
        // payload, also the unreachable length phase
        if (remaining != '0) remaining = remaining - 16'd1;
        r = '{payload_byte: b, stream_is_audio: audio, last_byte: (remaining == '0),
              empty_packet: 1'b0};
        expected_results.push_back(r);
        if (remaining == '0) rescan();
      end
    end
  endtask

  task automatic push_header(input bit audio, input logic [15:0] len);
    stream_bytes.push_back(CODE_PREFIX[23:16]);
    stream_bytes.push_back(CODE_PREFIX[15:8]);
    stream_bytes.push_back(CODE_PREFIX[7:0]);
    stream_bytes.push_back(audio ? ID_AUDIO : ID_VIDEO);
    stream_bytes.push_back(len[15:8]);
    stream_bytes.push_back(len[7:0]);
  endtask

  // well-formed packet with random content, sometimes hiding a start code
  task automatic push_packet(input bit audio, input int len);
    int hide_at;
    hide_at = -1;
    push_header(audio, len[15:0]);
    if (len >= 4 && $urandom_range(0, 5) == 0) hide_at = $urandom_range(0, len - 4);
    for (int i = 0; i < len; i++) begin
      if (hide_at >= 0 && i >= hide_at && i < hide_at + 4) begin
        if (i - hide_at == 3) stream_bytes.push_back($urandom_range(0, 1) ? ID_AUDIO : ID_VIDEO);
        else stream_bytes.push_back(CODE_PREFIX[8 * (2 - (i - hide_at)) +: 8]);
      end else begin
        stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic push_filler(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0: stream_bytes.push_back(CODE_PREFIX[23:16]);
        1: stream_bytes.push_back(CODE_PREFIX[7:0]);
        2: stream_bytes.push_back($urandom_range(0, 1) ? ID_AUDIO : ID_VIDEO);
        default: stream_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // prefix followed by a stream id that is not video or audio
  task automatic push_broken_header();
    logic [7:0] id;
    id = 8'($urandom_range(0, 255));
    while (id == ID_VIDEO || id == ID_AUDIO) id = 8'($urandom_range(0, 255));
    stream_bytes.push_back(CODE_PREFIX[23:16]);
    stream_bytes.push_back(CODE_PREFIX[15:8]);
    stream_bytes.push_back(CODE_PREFIX[7:0]);
    stream_bytes.push_back(id);
  endtask

  initial begin
    bit big_done;
    big_done = 1'b0;
    stream_ch.valid   = 1'b0;
    stream_ch.in_byte = 8'h00;
    packet_ch.ready   = 1'b0;
    rescan();
    pkt_len   = '0;
    remaining = '0;

    // a cleared window already holds the leading zeros: 01 E0 is a start
    stream_bytes.push_back(CODE_PREFIX[7:0]);
    stream_bytes.push_back(ID_VIDEO);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h01);
    stream_bytes.push_back(8'hFF);
    // same after a packet end, here with a zero-length audio packet
    stream_bytes.push_back(CODE_PREFIX[7:0]);
    stream_bytes.push_back(ID_AUDIO);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h00);
    // near miss, then a zero-length video packet
    push_broken_header();
    push_header(1'b0, 16'h0000);
    // payload carrying a start code is passed through untouched
    push_header(1'b1, 16'h0004);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h01);
    stream_bytes.push_back(ID_VIDEO);
    stream_bytes.push_back(8'hA5);

    while (stream_bytes.size() < PAYLOAD_TARGET) begin
      if (!big_done && stream_bytes.size() > PAYLOAD_TARGET / 3) begin
        big_done = 1'b1;
        push_packet(1'($urandom_range(0, 1)), 16'h0100 + $urandom_range(0, 3));
      end else begin
        case ($urandom_range(0, 9))
          0: push_filler($urandom_range(1, 4));
          1: push_broken_header();
          2: push_packet(1'($urandom_range(0, 1)), 0);
          default: push_packet(1'($urandom_range(0, 1)), $urandom_range(1, 12));
        endcase
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (stream_bytes.size() != 0 || stream_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (END_PAUSE) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // stream driver
  always @(negedge clk) begin
    if (rst) begin
      stream_ch.valid <= 1'b0;
    end else if (stream_ch.valid && !byte_taken) begin
      // hold the beat until it is taken
    end else if (src_gap > 0) begin
      src_gap--;
      stream_ch.valid <= 1'b0;
    end else if (stream_bytes.size() == 0) begin
      stream_ch.valid <= 1'b0;
    end else if (!steady() && $urandom_range(0, 4) == 0) begin
      src_gap = $urandom_range(0, 5);
      stream_ch.valid <= 1'b0;
    end else begin
      stream_ch.valid   <= 1'b1;
      stream_ch.in_byte <= stream_bytes.pop_front();
    end
  end

  // packet back-pressure
  always @(negedge clk) begin
    if (sink_gap > 0) begin
      sink_gap--;
      packet_ch.ready <= 1'b0;
    end else if (!steady() && $urandom_range(0, 4) == 0) begin
      sink_gap = $urandom_range(0, 5);
      packet_ch.ready <= 1'b0;
    end else begin
      packet_ch.ready <= 1'b1;
    end
  end

  // monitor: check results, then predict from the accepted byte
  always @(posedge clk) begin
    mpd_pkg::result_t want;
    bit               result_taken;
    byte_taken   = !rst && stream_ch.valid && stream_ch.ready;
    result_taken = !rst && packet_ch.valid && packet_ch.ready;
    if (result_taken) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, payload_byte", int'(packet_ch.payload_byte), 0);
      end else begin
        want = expected_results.pop_front();
        if (packet_ch.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", int'(packet_ch.payload_byte),
                          int'(want.payload_byte));
        if (packet_ch.stream_is_audio !== want.stream_is_audio)
          report_mismatch("stream_is_audio", int'(packet_ch.stream_is_audio),
                          int'(want.stream_is_audio));
        if (packet_ch.last_byte !== want.last_byte)
          report_mismatch("last_byte", int'(packet_ch.last_byte), int'(want.last_byte));
        if (packet_ch.empty_packet !== want.empty_packet)
          report_mismatch("empty_packet", int'(packet_ch.empty_packet),
                          int'(want.empty_packet));
      end
    end
    if (byte_taken) deframe_byte(stream_ch.in_byte);
  end

  // watchdog: count cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (stream_ch.valid && stream_ch.ready) || (packet_ch.valid && packet_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
